// File: design/puv_pkg.sv
// Shared types and constants for the PKCS#1 v1.5 signature unpad block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package puv_pkg;

  localparam int MAX_BYTES_DEF   = 512;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [12:0] MODULUS_BITS_RST   = 13'd2048;
  localparam logic [9:0]  MESSAGE_LENGTH_RST = 10'd256;
  localparam logic [9:0]  OUT_CAPACITY_RST   = 10'd256;

  localparam logic [1:0] CFG_MODULUS_BITS   = 2'd0;
  localparam logic [1:0] CFG_MESSAGE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_OUT_CAPACITY   = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LENGTH = 3'd1;
  localparam logic [2:0] ST_HEADER = 3'd2;
  localparam logic [2:0] ST_NOSEP  = 3'd3;
  localparam logic [2:0] ST_SMALL  = 3'd4;

  localparam logic [7:0]  BYTE_ZERO   = 8'h00;
  localparam logic [7:0]  BYTE_ONE    = 8'h01;
  localparam logic [7:0]  BYTE_PAD    = 8'hFF;
  localparam logic [10:0] MIN_MOD_LEN = 11'd11;

  typedef struct packed {
    logic [12:0] modulus_bits;
    logic [9:0]  message_length;
    logic [9:0]  out_capacity;
  } cfg_t;

  // one classified input byte: an optional payload item and an optional status item
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic       has_stat;
    logic [2:0] status;
    logic [9:0] plen;
  } job_t;

endpackage

// File: design/puv_front.sv
// Front end: accepts bytes, tracks the block phase, classifies each byte into a job.
// Depends on puv_pkg.
`timescale 1ns / 1ps
module puv_front import puv_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       acc,
  input  logic [7:0] data_byte,
  output logic       job_we,
  output job_t       job
);

  typedef enum logic [2:0] {
    PH_HEAD0 = 3'd0,
    PH_HEAD1 = 3'd1,
    PH_PAD   = 3'd2,
    PH_DATA  = 3'd3,
    PH_SINK  = 3'd4
  } phase_t;

  localparam logic [10:0] MaxLen = 11'(MAX_BYTES);

  phase_t      phase_r, phase_nxt, phase_upd;
  logic [9:0]  byte_index_r, byte_index_nxt;
  logic [2:0]  error_code_r, error_code_nxt, err_upd;
  logic [9:0]  payload_size_r, payload_size_nxt, psize_upd;
  logic        is_last, len_bad;
  logic [10:0] mod_len, len_ext;
  logic [9:0]  pay;
  logic [2:0]  st;
  logic [9:0]  plen;

  always_comb begin
    len_ext = {1'b0, cfg.message_length};
    is_last = ({1'b0, byte_index_r} + 11'd1) >= len_ext;
    mod_len = {1'b0, cfg.modulus_bits[12:3]} + {10'd0, |cfg.modulus_bits[2:0]};
    len_bad = (cfg.message_length == 10'd0) || (len_ext > MaxLen) ||
              (len_ext > mod_len) || (mod_len < MIN_MOD_LEN);
    pay = is_last ? 10'd0 : (cfg.message_length - 10'd1 - byte_index_r);

    phase_upd = phase_r;
    err_upd   = error_code_r;
    psize_upd = payload_size_r;
    case (phase_r)
      PH_HEAD0: begin
        if (len_bad) begin
          phase_upd = PH_SINK;
          err_upd   = ST_LENGTH;
        end else if (data_byte != BYTE_ZERO) begin
          phase_upd = PH_SINK;
          err_upd   = ST_HEADER;
        end else begin
          phase_upd = PH_HEAD1;
        end
      end
      PH_HEAD1: begin
        if (data_byte != BYTE_ONE) begin
          phase_upd = PH_SINK;
          err_upd   = ST_HEADER;
        end else begin
          phase_upd = PH_PAD;
        end
      end
      PH_PAD: begin
        if (data_byte == BYTE_ZERO) begin
          psize_upd = pay;
          if (pay > cfg.out_capacity) begin
            phase_upd = PH_SINK;
            err_upd   = ST_SMALL;
          end else begin
            phase_upd = PH_DATA;
          end
        end else if (data_byte != BYTE_PAD) begin
          phase_upd = PH_SINK;
          err_upd   = ST_NOSEP;
        end
      end
      default: ;
    endcase

    plen = 10'd0;
    case (phase_upd)
      PH_HEAD0, PH_HEAD1: st = ST_HEADER;
      PH_PAD:             st = ST_NOSEP;
      PH_DATA: begin
        st   = ST_OK;
        plen = psize_upd;
      end
      default: begin
        st = err_upd;
        if (err_upd == ST_SMALL) plen = psize_upd;
      end
    endcase

    job.has_pay  = (phase_r == PH_DATA);
    job.pay_byte = data_byte;
    job.has_stat = is_last;
    job.status   = st;
    job.plen     = plen;
    job_we       = acc && (job.has_pay || job.has_stat);

    phase_nxt        = phase_r;
    byte_index_nxt   = byte_index_r;
    error_code_nxt   = error_code_r;
    payload_size_nxt = payload_size_r;
    if (acc) begin
      if (is_last) begin
        phase_nxt        = PH_HEAD0;
        byte_index_nxt   = 10'd0;
        error_code_nxt   = ST_OK;
        payload_size_nxt = 10'd0;
      end else begin
        phase_nxt        = phase_upd;
        byte_index_nxt   = byte_index_r + 10'd1;
        error_code_nxt   = err_upd;
        payload_size_nxt = psize_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEAD0;
      byte_index_r   <= 10'd0;
      error_code_r   <= ST_OK;
      payload_size_r <= 10'd0;
    end else begin
      phase_r        <= phase_nxt;
      byte_index_r   <= byte_index_nxt;
      error_code_r   <= error_code_nxt;
      payload_size_r <= payload_size_nxt;
    end
  end

  a_sink_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SINK |-> error_code_r != ST_OK)
    else $error("sink phase without error code");

  a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_last |=> phase_r == PH_HEAD0 && byte_index_r == 10'd0)
    else $error("block state not cleared after last byte");

  a_index_moves: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_HEAD0 |-> byte_index_r != 10'd0)
    else $error("past first byte with zero index");

endmodule

// File: design/puv_fifo.sv
// Short job queue between the front end and the result stage.
// Depends on puv_pkg for job_t.
`timescale 1ns / 1ps
module puv_fifo import puv_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output logic nempty,
  output job_t rd_job
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  always_comb begin
    full   = (count_r == DepthC);
    nempty = (count_r != '0);
    rd_job = mem[rptr_r];
    do_wr  = wr_en && !full;
    do_rd  = rd_en && nempty;
    wptr_nxt  = do_wr ? ((wptr_r == LastPtr) ? '0 : wptr_r + 1'b1) : wptr_r;
    rptr_nxt  = do_rd ? ((rptr_r == LastPtr) ? '0 : rptr_r + 1'b1) : rptr_r;
    count_nxt = count_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/puv_back.sv
// Result stage: expands queued jobs into payload and status items.
// Depends on puv_pkg.
`timescale 1ns / 1ps
module puv_back import puv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_nempty,
  input  job_t       q_job,
  output logic       q_rd,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic [2:0] out_status,
  output logic [9:0] out_payload_length,
  output logic       out_last
);

  job_t cur_r, cur_nxt;
  logic cur_v_r, cur_v_nxt;
  logic take, final_item;

  always_comb begin
    out_empty  = !cur_v_r;
    take       = out_pop && cur_v_r;
    final_item = !(cur_r.has_pay && cur_r.has_stat);
    q_rd       = q_nempty && (!cur_v_r || (take && final_item));

    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    if (q_rd) begin
      cur_nxt   = q_job;
      cur_v_nxt = 1'b1;
    end else if (take) begin
      if (final_item) cur_v_nxt = 1'b0;
      else cur_nxt.has_pay = 1'b0;
    end

    out_kind           = !cur_r.has_pay;
    out_payload_byte   = cur_r.has_pay ? cur_r.pay_byte : 8'd0;
    out_status         = cur_r.has_pay ? ST_OK : cur_r.status;
    out_payload_length = cur_r.has_pay ? 10'd0 : cur_r.plen;
    out_last           = !cur_r.has_pay;
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
    end
  end

endmodule

// File: design/pkcs1_v15_signature_unpad_top.sv
// PKCS#1 v1.5 signature unpad block: top level with configuration registers.
// Depends on puv_pkg, puv_front, puv_fifo, puv_back.
//
// Usage: push encoded block bytes, most significant first, on in_data_byte with
// in_push; a byte is taken when in_full is low. Each payload byte comes out as a
// kind 0 item; after the last byte of a block a kind 1 status item with last set
// follows. Results are read like a queue: out_empty low means an item is shown,
// out_pop takes it.
// Throughput: one byte per cycle in while in_full is low; one result item per
// cycle out while items are queued. A block of N bytes yields at most N - 3
// payload items plus one status item. A taken byte's job is written into the
// queue and then loaded into the result register; a status item sharing a byte
// with a payload item is shown after that payload item is popped.
// The front end classifies bytes into a queue of QUEUE_DEPTH jobs; when the
// receiver stalls, that queue fills and in_full rises until out_pop resumes.
// Configuration (cfg_index 0 modulus bits, 1 message length, 2 output capacity)
// is always ready; write it only with no block in flight.
// Reset clears block state, queue and result valid flag, and loads the default
// configuration (2048 bits, 256 bytes, capacity 256).
`timescale 1ns / 1ps
module pkcs1_v15_signature_unpad_top import puv_pkg::*; #(
  parameter int MAX_BYTES   = MAX_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_status,
  output logic [9:0]  out_payload_length,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic in_acc, job_we, q_rd, q_nempty;
  job_t job, q_job;

  always_comb begin
    cfg_ready = 1'b1;
    cfg_nxt   = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MODULUS_BITS:   cfg_nxt.modulus_bits   = cfg_data;
        CFG_MESSAGE_LENGTH: cfg_nxt.message_length = cfg_data[9:0];
        CFG_OUT_CAPACITY:   cfg_nxt.out_capacity   = cfg_data[9:0];
        default: ;
      endcase
    end
    in_acc = in_push && !in_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{modulus_bits: MODULUS_BITS_RST, message_length: MESSAGE_LENGTH_RST,
                 out_capacity: OUT_CAPACITY_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  puv_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .acc       (in_acc),
    .data_byte (in_data_byte),
    .job_we    (job_we),
    .job       (job)
  );

  puv_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_we),
    .wr_job (job),
    .full   (in_full),
    .rd_en  (q_rd),
    .nempty (q_nempty),
    .rd_job (q_job)
  );

  puv_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_nempty           (q_nempty),
    .q_job              (q_job),
    .q_rd               (q_rd),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_status         (out_status),
    .out_payload_length (out_payload_length),
    .out_last           (out_last)
  );

endmodule
